>>> sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/mt64_pkg.sv
// Shared constants, types and functions of the 64-bit Mersenne Twister generator.
package mt64_pkg;

    localparam int STATE_WORDS   = 312;
    localparam int SHIFT_MID     = STATE_WORDS / 2;
    localparam int IDX_W         = 9;
    localparam int KEY_DEPTH_DEF = 16;
    localparam int CFG_ADDR_W    = 4;

    localparam logic [IDX_W-1:0] IDX_FULL     = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(STATE_WORDS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(STATE_WORDS - 1);

    localparam logic [63:0] TWIST_MATRIX    = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] HIGH_MASK       = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] LOW_MASK        = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] INIT_MULT       = 64'd6364136223846793005;
    localparam logic [63:0] ARRAY_MULT_A    = 64'd3935559000370003845;
    localparam logic [63:0] ARRAY_MULT_B    = 64'd2862933555777941757;
    localparam logic [63:0] ARRAY_BASE_SEED = 64'd19650218;
    localparam logic [63:0] DEFAULT_SEED    = 64'd5489;
    localparam logic [63:0] TOP_BIT_WORD    = 64'h8000_0000_0000_0000;

    // Action codes of an input word.
    localparam logic [1:0] ACT_DRAW = 2'd0;
    localparam logic [1:0] ACT_SEED = 2'd1;
    localparam logic [1:0] ACT_LOAD = 2'd2;
    localparam logic [1:0] ACT_KEYS = 2'd3;

    // Register byte addresses.
    localparam logic [CFG_ADDR_W-1:0] ADDR_SEED      = 4'h0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_KEY_COUNT = 4'h8;

    // Request and response of the shared multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

    // Folds the top two bits into the word before the seeding multiply.
    function automatic logic [63:0] seed_mix(input logic [63:0] p);
        return p ^ (p >> 62);
    endfunction

    // Output tempering.
    function automatic logic [63:0] temper(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
        x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
        x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
        x = x ^ (x >> 43);
        return x;
    endfunction

endpackage

>>> sv/mt64_mul.sv
// Iterative 64-bit by 64-bit multiplier keeping the low 64 bits of the product.
module mt64_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  mt64_pkg::mul_req_t req,
    output mt64_pkg::mul_rsp_t rsp
);
    import mt64_pkg::*;

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic        done_reg, done_next;
    logic [31:0] op_a, op_b;

    // One 32x32 partial product per cycle; the cross terms only reach the upper half.
    always_comb
    begin
        case (cnt_reg)
            3'd1:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[31:0];
            end
            3'd2:
            begin
                op_a = a_reg[63:32];
                op_b = b_reg[31:0];
            end
            default:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[63:32];
            end
        endcase
    end

    // Sequencing of the partial products and the accumulation.
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        case (cnt_reg)
            3'd1:
            begin
                prod_next = 64'(op_a) * 64'(op_b);
                cnt_next  = 3'd2;
            end
            3'd2:
            begin
                acc_next  = prod_reg;
                prod_next = 64'(op_a) * 64'(op_b);
                cnt_next  = 3'd3;
            end
            3'd3:
            begin
                acc_next  = acc_reg + {prod_reg[31:0], 32'd0};
                prod_next = 64'(op_a) * 64'(op_b);
                cnt_next  = 3'd4;
            end
            3'd4:
            begin
                acc_next  = acc_reg + {prod_reg[31:0], 32'd0};
                cnt_next  = 3'd0;
                done_next = 1'b1;
            end
            default:
            begin
                if (req.start)
                begin
                    a_next   = req.a;
                    b_next   = req.b;
                    cnt_next = 3'd1;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

>>> sv/mt64_core.sv
// State memory, key store and the sequencer for draw, twist and reseed.
module mt64_core #(
    parameter int KEY_DEPTH = mt64_pkg::KEY_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         action,
    input  logic [3:0]         key_slot,
    input  logic [63:0]        key_value,
    input  logic [63:0]        seed,
    input  logic [4:0]         key_count,
    output logic               busy,
    output logic [63:0]        random_word,
    output logic               word_valid,
    output mt64_pkg::mul_req_t mul_req,
    input  mt64_pkg::mul_rsp_t mul_rsp
);
    import mt64_pkg::*;

    localparam int KI_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LEN_W = $clog2(KEY_DEPTH + 1);

    typedef enum logic [16:0] {
        ST_IDLE      = 17'h00001,
        ST_SEED_W0   = 17'h00002,
        ST_SEED_GO   = 17'h00004,
        ST_SEED_WAIT = 17'h00008,
        ST_A1_GO     = 17'h00010,
        ST_A1_WAIT   = 17'h00020,
        ST_A1_WRAP   = 17'h00040,
        ST_A2_GO     = 17'h00080,
        ST_A2_WAIT   = 17'h00100,
        ST_A2_WRAP   = 17'h00200,
        ST_FINAL     = 17'h00400,
        ST_T_PRIME   = 17'h00800,
        ST_T_PRIME_W = 17'h01000,
        ST_T_RD      = 17'h02000,
        ST_T_CALC    = 17'h04000,
        ST_D_RD      = 17'h08000,
        ST_D_OUT     = 17'h10000
    } state_t;

    // What follows a single-word seeding pass.
    typedef enum logic [1:0] {
        AFT_IDLE  = 2'd0,
        AFT_ARRAY = 2'd1,
        AFT_TWIST = 2'd2
    } after_t;

    state_t                 state_reg, state_next;
    after_t                 after_reg, after_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [KI_W-1:0]        j_reg, j_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [63:0]            p_reg, p_next;
    logic [63:0]            cur_reg, cur_next;
    logic [63:0]            out_reg, out_next;
    logic                   outv_reg, outv_next;

    logic [63:0]            st_mem [STATE_WORDS];
    logic [63:0]            key_mem [KEY_DEPTH];
    logic [63:0]            rda_reg, rdb_reg, rdk_reg;

    logic                   sa_ren, sb_ren, s_wen, k_ren, k_wen;
    logic [IDX_W-1:0]       sa_addr, sb_addr, s_waddr;
    logic [63:0]            s_wdata;
    logic [KI_W-1:0]        k_raddr, k_waddr;

    logic [31:0]            slot32, kc32, len32;
    logic [IDX_W-1:0]       nx_addr, far_addr;
    logic [63:0]            tw_x, step_val;

    // Neighbour and far addresses of the word being twisted.
    assign nx_addr  = (n_reg == IDX_LAST) ? '0 : n_reg + 1'b1;
    assign far_addr = (n_reg < IDX_W'(SHIFT_MID)) ? n_reg + IDX_W'(SHIFT_MID)
                                                   : n_reg - IDX_W'(SHIFT_MID);
    assign tw_x     = (cur_reg & HIGH_MASK) | (rda_reg & LOW_MASK);

    // Key geometry: slot address and the clamped key length.
    assign slot32  = 32'(key_slot);
    assign k_waddr = slot32[KI_W-1:0];
    assign kc32    = 32'(key_count);
    always_comb
    begin
        if (kc32 == 32'd0)
        begin
            len32 = 32'd1;
        end
        else if (kc32 > 32'(KEY_DEPTH))
        begin
            len32 = 32'(KEY_DEPTH);
        end
        else
        begin
            len32 = kc32;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        len_next   = len_reg;
        p_next     = p_reg;
        cur_next   = cur_reg;
        out_next   = out_reg;
        outv_next  = 1'b0;
        sa_ren     = 1'b0;
        sb_ren     = 1'b0;
        sa_addr    = '0;
        sb_addr    = '0;
        s_wen      = 1'b0;
        s_waddr    = '0;
        s_wdata    = '0;
        k_ren      = 1'b0;
        k_raddr    = j_reg;
        k_wen      = 1'b0;
        step_val   = '0;
        mul_req    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_DRAW:
                        begin
                            if (idx_reg == IDX_UNSEEDED)
                            begin
                                p_next     = DEFAULT_SEED;
                                after_next = AFT_TWIST;
                                state_next = ST_SEED_W0;
                            end
                            else if (idx_reg >= IDX_FULL)
                            begin
                                state_next = ST_T_PRIME;
                            end
                            else
                            begin
                                state_next = ST_D_RD;
                            end
                        end
                        ACT_SEED:
                        begin
                            p_next     = seed;
                            after_next = AFT_IDLE;
                            state_next = ST_SEED_W0;
                        end
                        ACT_LOAD:
                        begin
                            k_wen = (slot32 < 32'(KEY_DEPTH));
                        end
                        ACT_KEYS:
                        begin
                            p_next     = ARRAY_BASE_SEED;
                            after_next = AFT_ARRAY;
                            len_next   = len32[LEN_W-1:0];
                            state_next = ST_SEED_W0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Single-word seeding, one multiply per word.
            ST_SEED_W0:
            begin
                s_wen      = 1'b1;
                s_waddr    = '0;
                s_wdata    = p_reg;
                n_next     = IDX_W'(1);
                state_next = ST_SEED_GO;
            end
            ST_SEED_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = seed_mix(p_reg);
                mul_req.b     = INIT_MULT;
                state_next    = ST_SEED_WAIT;
            end
            ST_SEED_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    step_val = mul_rsp.product + 64'(n_reg);
                    s_wen    = 1'b1;
                    s_waddr  = n_reg;
                    s_wdata  = step_val;
                    p_next   = step_val;
                    if (n_reg == IDX_LAST)
                    begin
                        idx_next = IDX_FULL;
                        unique case (after_reg)
                            AFT_TWIST:
                            begin
                                state_next = ST_T_PRIME;
                            end
                            AFT_ARRAY:
                            begin
                                p_next     = ARRAY_BASE_SEED;
                                n_next     = IDX_W'(1);
                                j_next     = '0;
                                k_next     = IDX_FULL;
                                state_next = ST_A1_GO;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        n_next     = n_reg + 1'b1;
                        state_next = ST_SEED_GO;
                    end
                end
            end

            // First array pass: mixes in the key words.
            ST_A1_GO:
            begin
                sa_ren        = 1'b1;
                sa_addr       = n_reg;
                k_ren         = 1'b1;
                mul_req.start = 1'b1;
                mul_req.a     = seed_mix(p_reg);
                mul_req.b     = ARRAY_MULT_A;
                state_next    = ST_A1_WAIT;
            end
            ST_A1_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    step_val = (rda_reg ^ mul_rsp.product) + rdk_reg + 64'(j_reg);
                    s_wen    = 1'b1;
                    s_waddr  = n_reg;
                    s_wdata  = step_val;
                    p_next   = step_val;
                    k_next   = k_reg - 1'b1;
                    if (32'(j_reg) + 32'd1 >= 32'(len_reg))
                    begin
                        j_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    if (n_reg == IDX_LAST)
                    begin
                        state_next = ST_A1_WRAP;
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                        if (k_reg == IDX_W'(1))
                        begin
                            k_next     = IDX_LAST;
                            state_next = ST_A2_GO;
                        end
                        else
                        begin
                            state_next = ST_A1_GO;
                        end
                    end
                end
            end
            ST_A1_WRAP:
            begin
                s_wen   = 1'b1;
                s_waddr = '0;
                s_wdata = p_reg;
                n_next  = IDX_W'(1);
                if (k_reg == '0)
                begin
                    k_next     = IDX_LAST;
                    state_next = ST_A2_GO;
                end
                else
                begin
                    state_next = ST_A1_GO;
                end
            end

            // Second array pass.
            ST_A2_GO:
            begin
                sa_ren        = 1'b1;
                sa_addr       = n_reg;
                mul_req.start = 1'b1;
                mul_req.a     = seed_mix(p_reg);
                mul_req.b     = ARRAY_MULT_B;
                state_next    = ST_A2_WAIT;
            end
            ST_A2_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    step_val = (rda_reg ^ mul_rsp.product) - 64'(n_reg);
                    s_wen    = 1'b1;
                    s_waddr  = n_reg;
                    s_wdata  = step_val;
                    p_next   = step_val;
                    k_next   = k_reg - 1'b1;
                    if (n_reg == IDX_LAST)
                    begin
                        state_next = ST_A2_WRAP;
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                        if (k_reg == IDX_W'(1))
                        begin
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            state_next = ST_A2_GO;
                        end
                    end
                end
            end
            ST_A2_WRAP:
            begin
                s_wen   = 1'b1;
                s_waddr = '0;
                s_wdata = p_reg;
                n_next  = IDX_W'(1);
                if (k_reg == '0)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_A2_GO;
                end
            end
            ST_FINAL:
            begin
                s_wen      = 1'b1;
                s_waddr    = '0;
                s_wdata    = TOP_BIT_WORD;
                idx_next   = IDX_FULL;
                state_next = ST_IDLE;
            end

            // Twist in place; the old word at n is carried over from the previous read.
            ST_T_PRIME:
            begin
                sa_ren     = 1'b1;
                sa_addr    = '0;
                state_next = ST_T_PRIME_W;
            end
            ST_T_PRIME_W:
            begin
                cur_next   = rda_reg;
                n_next     = '0;
                state_next = ST_T_RD;
            end
            ST_T_RD:
            begin
                sa_ren     = 1'b1;
                sa_addr    = nx_addr;
                sb_ren     = 1'b1;
                sb_addr    = far_addr;
                state_next = ST_T_CALC;
            end
            ST_T_CALC:
            begin
                s_wen    = 1'b1;
                s_waddr  = n_reg;
                s_wdata  = rdb_reg ^ (tw_x >> 1) ^ (tw_x[0] ? TWIST_MATRIX : 64'd0);
                cur_next = rda_reg;
                if (n_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_D_RD;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_T_RD;
                end
            end

            // Draw one word.
            ST_D_RD:
            begin
                sa_ren     = 1'b1;
                sa_addr    = idx_reg;
                state_next = ST_D_OUT;
            end
            ST_D_OUT:
            begin
                out_next   = temper(rda_reg);
                outv_next  = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            after_reg <= AFT_IDLE;
            idx_reg   <= IDX_UNSEEDED;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            idx_reg   <= idx_next;
            outv_reg  <= outv_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        k_reg   <= k_next;
        j_reg   <= j_next;
        len_reg <= len_next;
        p_reg   <= p_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // State memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (s_wen)
        begin
            st_mem[s_waddr] <= s_wdata;
        end
        if (sa_ren)
        begin
            rda_reg <= st_mem[sa_addr];
        end
        if (sb_ren)
        begin
            rdb_reg <= st_mem[sb_addr];
        end
    end

    // Key store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (k_wen)
        begin
            key_mem[k_waddr] <= key_value;
        end
        if (k_ren)
        begin
            rdk_reg <= key_mem[k_raddr];
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign random_word = out_reg;
    assign word_valid  = outv_reg;

endmodule

>>> sv/mt19937_64_generator.sv
// Top level of the 64-bit Mersenne Twister generator with its register port.
//
// A word is accepted when start is high and busy is low. A draw keeps busy
// high for a state memory read and then tempering, and the result
// appears on random_word with word_valid high for exactly one cycle, in the
// cycle in which busy falls; it cannot be held off. Every 312th draw, and the
// first draw after a reseed, first twists the whole state in place through
// the dual-read state memory, with a read state and a write state per state
// word. An unseeded first draw also runs the default seeding first. Seeding
// from the seed register and the key-array reseed are paced by the shared
// 32x32 multiplier, which forms three partial products for every multiply.
// Loading a key word keeps busy low. Registers: seed at byte address 0x0,
// key_count at 0x8.
module mt19937_64_generator #(
    parameter int KEY_DEPTH = mt64_pkg::KEY_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          action,
    input  logic [3:0]                          key_slot,
    input  logic [63:0]                         key_value,
    output logic [63:0]                         random_word,
    output logic                                word_valid,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mt64_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [63:0]                         pwdata,
    output logic [63:0]                         prdata,
    output logic                                pready
);
    import mt64_pkg::*;

    logic [63:0] seed_reg;
    logic [4:0]  kc_reg;
    logic        cfg_wr;
    mul_req_t    mul_req;
    mul_rsp_t    mul_rsp;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= DEFAULT_SEED;
            kc_reg   <= 5'd4;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_SEED)
            begin
                seed_reg <= pwdata;
            end
            if (paddr == ADDR_KEY_COUNT)
            begin
                kc_reg <= pwdata[4:0];
            end
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr)
            ADDR_SEED:      prdata = seed_reg;
            ADDR_KEY_COUNT: prdata = 64'(kc_reg);
            default:        prdata = '0;
        endcase
    end

    mt64_core #(
        .KEY_DEPTH(KEY_DEPTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .key_slot    (key_slot),
        .key_value   (key_value),
        .seed        (seed_reg),
        .key_count   (kc_reg),
        .busy        (busy),
        .random_word (random_word),
        .word_valid  (word_valid),
        .mul_req     (mul_req),
        .mul_rsp     (mul_rsp)
    );

    mt64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

endmodule

>>> sv/mt64_checker.sv
// Port-level checks of the generator and their binding to the top level.
`include "assert_macros.svh"

module mt64_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] action,
    input logic       word_valid
);
    import mt64_pkg::*;

    // A result only appears once the block has returned to idle.
    `MT_ASSERT_IMP(a_valid_idle, clk, rst_n, word_valid, !busy)
    // A result is a single-cycle strobe.
    `MT_ASSERT_NXT(a_valid_single, clk, rst_n, word_valid, !word_valid)
    // An accepted non-draw word never yields a result in the next cycle.
    `MT_ASSERT_NXT(a_no_result, clk, rst_n, start && !busy && action != ACT_DRAW, !word_valid)
    // A key load finishes at once and a draw always occupies the block.
    `MT_ASSERT_NXT(a_load_idle, clk, rst_n, start && !busy && action == ACT_LOAD, !busy)
    `MT_ASSERT_NXT(a_draw_busy, clk, rst_n, start && !busy && action == ACT_DRAW, busy)

endmodule

bind mt19937_64_generator mt64_checker u_checker (.*);

>>> sim/mt19937_64_generator_test.sv
// Self-checking testbench of the 64-bit Mersenne Twister generator.
module mt19937_64_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mt64_pkg::*;

    localparam int KEYS = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]  act;
        logic [3:0]  slot;
        logic [63:0] val;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [3:0]  key_slot;
    logic [63:0] key_value;
    logic [63:0] random_word;
    logic        word_valid;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Words waiting for the driver, and draws waiting for their result.
    word_t       pending_words[$];
    logic [63:0] expected_draws[$];
    int          errors;
    bit          steady;
    longint      cycles;

    // Predictor copy of the generator state and registers.
    logic [63:0] gen_state [0:STATE_WORDS-1];
    int unsigned gen_pos;
    logic [63:0] gen_keys [0:KEYS-1];
    logic [63:0] reg_seed;
    logic [4:0]  reg_key_count;

    mt19937_64_generator i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .key_slot(key_slot), .key_value(key_value),
        .random_word(random_word), .word_valid(word_valid),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    // Fills the state from a single seed word.
    task automatic fill_from_seed(input logic [63:0] s);
        logic [63:0] p;
        gen_state[0] = s;
        for (int n = 1; n < STATE_WORDS; n++)
        begin
            p = gen_state[n-1];
            gen_state[n] = INIT_MULT * (p ^ (p >> 62)) + 64'(n);
        end
        gen_pos = STATE_WORDS;
    endtask

    // Mixes the key store into the state.
    task automatic fill_from_keys();
        int unsigned len;
        int unsigned i;
        int unsigned j;
        logic [63:0] p;
        len = reg_key_count;
        if (len == 0)
            len = 1;
        if (len > KEYS)
            len = KEYS;
        fill_from_seed(ARRAY_BASE_SEED);
        i = 1;
        j = 0;
        for (int k = STATE_WORDS; k > 0; k--)
        begin
            p = gen_state[i-1];
            gen_state[i] = (gen_state[i] ^ ((p ^ (p >> 62)) * ARRAY_MULT_A))
                           + gen_keys[j] + 64'(j);
            i++;
            j++;
            if (i >= STATE_WORDS)
            begin
                gen_state[0] = gen_state[STATE_WORDS-1];
                i = 1;
            end
            if (j >= len)
                j = 0;
        end
        for (int k = STATE_WORDS - 1; k > 0; k--)
        begin
            p = gen_state[i-1];
            gen_state[i] = (gen_state[i] ^ ((p ^ (p >> 62)) * ARRAY_MULT_B)) - 64'(i);
            i++;
            if (i >= STATE_WORDS)
            begin
                gen_state[0] = gen_state[STATE_WORDS-1];
                i = 1;
            end
        end
        gen_state[0] = TOP_BIT_WORD;
        gen_pos = STATE_WORDS;
    endtask

    // Regenerates all state words in place.
    task automatic twist_all();
        logic [63:0] x;
        for (int n = 0; n < STATE_WORDS; n++)
        begin
            x = (gen_state[n] & HIGH_MASK) | (gen_state[(n + 1) % STATE_WORDS] & LOW_MASK);
            gen_state[n] = gen_state[(n + SHIFT_MID) % STATE_WORDS] ^ (x >> 1)
                           ^ (x[0] ? TWIST_MATRIX : 64'd0);
        end
    endtask

    // Applies one accepted word to the predictor.
    task automatic apply_word(input word_t w);
        logic [63:0] y;
        case (w.act)
            ACT_DRAW:
            begin
                if (gen_pos >= STATE_WORDS)
                begin
                    if (gen_pos == STATE_WORDS + 1)
                        fill_from_seed(DEFAULT_SEED);
                    twist_all();
                    gen_pos = 0;
                end
                y = gen_state[gen_pos];
                y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
                y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
                y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
                y = y ^ (y >> 43);
                expected_draws.push_back(y);
                gen_pos++;
            end
            ACT_SEED:
                fill_from_seed(reg_seed);
            ACT_LOAD:
                gen_keys[w.slot] = w.val;
            default:
                fill_from_keys();
        endcase
    endtask

    // Driver: offers queued words, idling at random outside the steady stretch.
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n)
        begin
            if (start && !busy)
                apply_word('{action, key_slot, key_value});
            if (!start || !busy)
            begin
                if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 23))
                begin
                    w = pending_words.pop_front();
                    start <= 1'b1;
                    action <= w.act;
                    key_slot <= w.slot;
                    key_value <= w.val;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: each result word against the oldest expected draw.
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && word_valid)
        begin
            if (expected_draws.size() == 0)
            begin
                $display("%0t: unexpected word %h", $realtime, random_word);
                errors++;
            end
            else
            begin
                want = expected_draws.pop_front();
                if (random_word !== want)
                begin
                    $display("%0t: random_word expected %h actual %h",
                             $realtime, want, random_word);
                    errors++;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_word(input logic [1:0] a, input logic [3:0] s, input logic [63:0] v);
        pending_words.push_back('{a, s, v});
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SEED)
            reg_seed = data;
        else
            reg_key_count = data[4:0];
    endtask

    // Waits until every word is taken, every draw answered and the block is quiet.
    task automatic wait_quiet();
        for (int pass = 0; pass < 2; pass++)
        begin
            while (pending_words.size() > 0 || start || expected_draws.size() > 0 || busy)
                @(posedge clk);
            repeat (10) @(posedge clk);
        end
    endtask

    task automatic random_mix(input int count);
        int unsigned r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 78)
                add_word(ACT_DRAW, 4'($urandom), {$urandom, $urandom});
            else if (r < 90)
                add_word(ACT_LOAD, 4'($urandom), {$urandom, $urandom});
            else if (r < 95)
                add_word(ACT_SEED, 4'($urandom), {$urandom, $urandom});
            else
                add_word(ACT_KEYS, 4'($urandom), {$urandom, $urandom});
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_DRAW;
        key_slot = '0;
        key_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        steady = 1'b0;
        cycles = 0;
        gen_pos = STATE_WORDS + 1;
        reg_seed = DEFAULT_SEED;
        reg_key_count = 5'd4;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: an unseeded draw and a second draw, full key store load, both reseeds.
        add_word(ACT_DRAW, 4'd0, 64'd0);
        add_word(ACT_DRAW, 4'hF, '1);
        for (int s = 0; s < KEYS; s++)
            add_word(ACT_LOAD, 4'(s), (s == 0) ? 64'd0 : (s == 1) ? '1 : {$urandom, $urandom});
        add_word(ACT_KEYS, 4'd0, 64'd0);
        add_word(ACT_DRAW, 4'd0, 64'd0);
        add_word(ACT_SEED, 4'd0, 64'd0);
        add_word(ACT_DRAW, 4'd0, 64'd0);
        add_word(ACT_DRAW, 4'd0, 64'd0);
        wait_quiet();

        // Register settings: zero and saturating key counts, extreme seeds.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin reg_write(ADDR_SEED, 64'd0); reg_write(ADDR_KEY_COUNT, 64'd0); end
                1: begin reg_write(ADDR_SEED, '1); reg_write(ADDR_KEY_COUNT, 64'd31); end
                2: begin reg_write(ADDR_SEED, {$urandom, $urandom});
                         reg_write(ADDR_KEY_COUNT, 64'd16); end
                3: begin reg_write(ADDR_SEED, {$urandom, $urandom});
                         reg_write(ADDR_KEY_COUNT, 64'd1); end
                default: begin reg_write(ADDR_SEED, {$urandom, $urandom});
                         reg_write(ADDR_KEY_COUNT, 64'($urandom_range(31))); end
            endcase
            if (phase == 2)
            begin
                // Long run of draws across a twist boundary, partly without idling.
                add_word(ACT_SEED, 4'd0, 64'd0);
                for (int n = 0; n < 330; n++)
                    add_word(ACT_DRAW, 4'($urandom), {$urandom, $urandom});
                steady = 1'b1;
                while (pending_words.size() > 150)
                    @(posedge clk);
                steady = 1'b0;
            end
            else
                random_mix(25);
            wait_quiet();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> mt19937_64_generator.f
+incdir+sv
sv/mt64_pkg.sv
sv/mt64_mul.sv
sv/mt64_core.sv
sv/mt19937_64_generator.sv
sv/mt64_checker.sv
sim/mt19937_64_generator_test.sv
